@@ design/fps_pkg.sv @@
// Shared types, constants and helpers for the frame pixel statistics block.
// No dependencies; every other design file imports this package.
package fps_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = POS_W + 1;
   localparam int TALLY_W     = 25;
   localparam int PIXEL_W     = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIXEL_W-1:0] ARGB_BLACK = 32'hff00_0000;
   localparam logic [PIXEL_W-1:0] ARGB_WHITE = 32'hffff_ffff;
   localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hff00_0000;
   localparam logic [PIXEL_W-1:0] RGB_MASK   = 32'h00ff_ffff;

   localparam logic [CSR_DATA_W-1:0] RESET_WIDTH  = 13'd1344;
   localparam logic [CSR_DATA_W-1:0] RESET_HEIGHT = 13'd2992;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } fps_dims_type;

   typedef struct packed {
      logic               is_zero;
      logic               is_black;
      logic               is_white;
      logic               is_alpha;
      logic               is_nonblack;
      logic               is_first;
      logic               is_middle;
      logic               is_last;
      logic [POS_W-1:0]   column;
      logic [POS_W-1:0]   row;
      logic [PIXEL_W-1:0] pixel;
   } fps_item_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_DATA_W-1:0] raw);
      logic [DIM_W-1:0] result;
      if (raw == '0) begin
         result = DIM_W'(1);
      end else if (DIM_W'(raw) > DIM_W'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = DIM_W'(raw);
      end
      return result;
   endfunction

endpackage

@@ design/fps_req_if.sv @@
// Pixel input channel: valid/ready handshake carrying one ARGB pixel.
// Depends on fps_pkg for the pixel width.
interface fps_req_if import fps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

@@ design/fps_rsp_if.sv @@
// Frame result channel: valid/ready handshake carrying the per-frame statistics.
// Depends on fps_pkg for field widths.
interface fps_rsp_if import fps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TALLY_W-1:0] zero_count;
   logic [TALLY_W-1:0] opaque_black_count;
   logic [TALLY_W-1:0] opaque_white_count;
   logic [TALLY_W-1:0] alpha_full_count;
   logic [TALLY_W-1:0] nonblack_count;
   logic [DIM_W-1:0]   box_min_x;
   logic [POS_W-1:0]   box_max_x;
   logic [DIM_W-1:0]   box_min_y;
   logic [POS_W-1:0]   box_max_y;
   logic [PIXEL_W-1:0] top_left_pixel;
   logic [PIXEL_W-1:0] center_pixel;
   logic [PIXEL_W-1:0] bottom_right_pixel;

   modport source (output valid, output zero_count, output opaque_black_count,
                   output opaque_white_count, output alpha_full_count,
                   output nonblack_count, output box_min_x, output box_max_x,
                   output box_min_y, output box_max_y, output top_left_pixel,
                   output center_pixel, output bottom_right_pixel, input ready);
   modport sink (input valid, input zero_count, input opaque_black_count,
                 input opaque_white_count, input alpha_full_count,
                 input nonblack_count, input box_min_x, input box_max_x,
                 input box_min_y, input box_max_y, input top_left_pixel,
                 input center_pixel, input bottom_right_pixel, output ready);
endinterface

@@ design/fps_front.sv @@
// Front end: accepts pixels, tracks the raster position and classifies each item.
// Depends on fps_pkg; feeds fps_queue.
module fps_front import fps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  fps_dims_type dims,
   input  logic         in_valid,
   input  logic [PIXEL_W-1:0] in_pixel,
   output logic         in_ready,
   input  logic         queue_ready,
   output logic         push,
   output fps_item_type item
);

   logic [POS_W-1:0] column_ff, column_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] last_column;
   logic [POS_W-1:0] last_row;
   logic [POS_W-1:0] mid_column;
   logic [POS_W-1:0] mid_row;
   logic             end_of_line;

   assign in_ready    = queue_ready;
   assign push        = in_valid && queue_ready;
   assign last_column = POS_W'(dims.width - DIM_W'(1));
   assign last_row    = POS_W'(dims.height - DIM_W'(1));
   assign mid_column  = dims.width[DIM_W-1:1];
   assign mid_row     = dims.height[DIM_W-1:1];
   assign end_of_line = (column_ff == last_column);

   always_comb begin
      item.is_zero     = (in_pixel == '0);
      item.is_black    = (in_pixel == ARGB_BLACK);
      item.is_white    = (in_pixel == ARGB_WHITE);
      item.is_alpha    = ((in_pixel & ALPHA_MASK) == ALPHA_MASK);
      item.is_nonblack = ((in_pixel & RGB_MASK) != '0);
      item.is_first    = (column_ff == '0) && (row_ff == '0);
      item.is_middle   = (column_ff == mid_column) && (row_ff == mid_row);
      item.is_last     = end_of_line && (row_ff == last_row);
      item.column      = column_ff;
      item.row         = row_ff;
      item.pixel       = in_pixel;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (push) begin
         if (!end_of_line) begin
            column_in = column_ff + POS_W'(1);
         end else if (row_ff != last_row) begin
            column_in = '0;
            row_in    = row_ff + POS_W'(1);
         end else begin
            column_in = '0;
            row_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   a_column_in_frame: assert property (@(posedge clock) disable iff (reset)
      DIM_W'(column_ff) < dims.width)
      else $error("column position outside frame");
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      DIM_W'(row_ff) < dims.height)
      else $error("row position outside frame");
   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (push && item.is_last && !clear) |=> (column_ff == '0 && row_ff == '0))
      else $error("position did not wrap after last pixel");

endmodule

@@ design/fps_queue.sv @@
// Short item queue between the front end and the accumulator back end.
// Depends on fps_pkg for the item type and depth.
module fps_queue import fps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         flush,
   input  logic         push,
   input  fps_item_type push_item,
   output logic         push_ready,
   input  logic         pop,
   output logic         pop_valid,
   output fps_item_type pop_item
);

   fps_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_push_only_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("push into full queue");
   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

@@ design/fps_back.sv @@
// Back end: accumulates tallies, bounding box and sampled pixels per frame,
// and holds the finished frame result. Depends on fps_pkg; reads fps_queue.
module fps_back import fps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  fps_dims_type clear_dims,
   input  logic         item_valid,
   input  fps_item_type item,
   output logic         item_pop,
   fps_rsp_if.source    rsp
);

   logic [TALLY_W-1:0] zero_ff, zero_in;
   logic [TALLY_W-1:0] black_ff, black_in;
   logic [TALLY_W-1:0] white_ff, white_in;
   logic [TALLY_W-1:0] full_alpha_ff, full_alpha_in;
   logic [TALLY_W-1:0] nonblack_ff, nonblack_in;
   logic [DIM_W-1:0]   left_ff, left_in;
   logic [POS_W-1:0]   right_ff, right_in;
   logic [DIM_W-1:0]   top_ff, top_in;
   logic [POS_W-1:0]   bottom_ff, bottom_in;
   logic [PIXEL_W-1:0] first_ff, first_in;
   logic [PIXEL_W-1:0] middle_ff, middle_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               back_ready;
   logic               finish;

   assign back_ready = !item.is_last || !rsp_valid_ff || rsp.ready;
   assign item_pop   = item_valid && back_ready;
   assign finish     = item_pop && item.is_last;

   always_comb begin
      zero_in       = zero_ff + TALLY_W'(item.is_zero);
      black_in      = black_ff + TALLY_W'(item.is_black);
      white_in      = white_ff + TALLY_W'(item.is_white);
      full_alpha_in = full_alpha_ff + TALLY_W'(item.is_alpha);
      nonblack_in   = nonblack_ff + TALLY_W'(item.is_nonblack);
      left_in       = left_ff;
      right_in      = right_ff;
      top_in        = top_ff;
      bottom_in     = bottom_ff;
      first_in      = item.is_first ? item.pixel : first_ff;
      middle_in     = item.is_middle ? item.pixel : middle_ff;
      if (item.is_nonblack) begin
         if (DIM_W'(item.column) < left_ff) left_in = DIM_W'(item.column);
         if (item.column > right_ff) right_in = item.column;
         if (DIM_W'(item.row) < top_ff) top_in = DIM_W'(item.row);
         if (item.row > bottom_ff) bottom_in = item.row;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear || finish) begin
         zero_ff       <= '0;
         black_ff      <= '0;
         white_ff      <= '0;
         full_alpha_ff <= '0;
         nonblack_ff   <= '0;
         left_ff       <= clear_dims.width;
         right_ff      <= '0;
         top_ff        <= clear_dims.height;
         bottom_ff     <= '0;
         first_ff      <= '0;
         middle_ff     <= '0;
      end else if (item_pop) begin
         zero_ff       <= zero_in;
         black_ff      <= black_in;
         white_ff      <= white_in;
         full_alpha_ff <= full_alpha_in;
         nonblack_ff   <= nonblack_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         top_ff        <= top_in;
         bottom_ff     <= bottom_in;
         first_ff      <= first_in;
         middle_ff     <= middle_in;
      end
   end

   // hold the finished frame until the result is taken
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp.zero_count         <= zero_in;
         rsp.opaque_black_count <= black_in;
         rsp.opaque_white_count <= white_in;
         rsp.alpha_full_count   <= full_alpha_in;
         rsp.nonblack_count     <= nonblack_in;
         rsp.box_min_x          <= left_in;
         rsp.box_max_x          <= right_in;
         rsp.box_min_y          <= top_in;
         rsp.box_max_y          <= bottom_in;
         rsp.top_left_pixel     <= first_in;
         rsp.center_pixel       <= middle_in;
         rsp.bottom_right_pixel <= item.pixel;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished frame not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp.ready))
      else $error("pending result overwritten");
   a_left_within_width: assert property (@(posedge clock) disable iff (reset)
      !clear |-> (left_ff <= clear_dims.width))
      else $error("left edge beyond frame width");
   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      (nonblack_ff == '0) |-> (right_ff == '0 && bottom_ff == '0))
      else $error("box edges set without nonblack pixels");

endmodule

@@ design/frame_pixel_statistics.sv @@
// Frame pixel statistics: per-frame tallies, nonblack bounding box and sampled pixels.
// Throughput one pixel per cycle while the queue has room; the result is registered
// when the back end takes a frame's last pixel. A two-item queue splits front and back:
// an unread result holds the next frame's last pixel at the queue head, and input
// stalls once one more item fills the queue. Synchronous reset restores 1344 x 2992
// and clears all frame state; a register write clears the frame in progress.
module frame_pixel_statistics import fps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   fps_req_if.sink                req,
   fps_rsp_if.source              rsp
);

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic                  clear;
   fps_dims_type          dims;
   fps_dims_type          clear_dims;
   logic                  front_push;
   logic                  queue_ready;
   fps_item_type          front_item;
   logic                  queue_valid;
   fps_item_type          queue_item;
   logic                  back_pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      clear     = 1'b0;
      if (reset) begin
         width_in  = RESET_WIDTH;
         height_in = RESET_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_in = csr_write_data;
               clear    = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_write_data;
               clear     = 1'b1;
            end
            default: clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign dims.width        = eff_dim(width_ff);
   assign dims.height       = eff_dim(height_ff);
   assign clear_dims.width  = eff_dim(width_in);
   assign clear_dims.height = eff_dim(height_in);

   fps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .dims        (dims),
      .in_valid    (req.valid),
      .in_pixel    (req.pixel_value),
      .in_ready    (req.ready),
      .queue_ready (queue_ready),
      .push        (front_push),
      .item        (front_item)
   );

   fps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (clear),
      .push       (front_push),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop        (back_pop),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item)
   );

   fps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .clear_dims (clear_dims),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (back_pop),
      .rsp        (rsp)
   );

endmodule
